[rtl/pcwm_pkg.sv]
// Package for the per-channel window minimum filter.
// Shared field widths, reset constants, sequencer states and the result record.
// No dependencies.
package pcwm_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned RANGE_W = 16;
	localparam int unsigned WIN_W   = 4;

	localparam logic [RANGE_W-1:0] FULL_RANGE = '1;
	localparam logic [WIN_W-1:0]   WIN_RESET  = 4'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PTR,
		ST_SCAN,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic               bad;
		logic [RANGE_W-1:0] min_range;
		logic [CH_W-1:0]    channel;
	} result_t;

endpackage

[rtl/pcwm_hist_mem.sv]
// History store of the window minimum filter: one write port, one read port.
// Read data is registered. Uses pcwm_pkg.
module pcwm_hist_mem #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [pcwm_pkg::RANGE_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [pcwm_pkg::RANGE_W-1:0] rd_data
);
	import pcwm_pkg::*;

	logic [RANGE_W-1:0] mem [DEPTH];
	logic [RANGE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/pcwm_ptr_mem.sv]
// Per-channel ring pointer store: {full flag, write position} per channel.
// Registered read; per-entry valid bits make unwritten entries read as zero.
module pcwm_ptr_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned CW    = 6,
	parameter int unsigned DW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [CW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written channel: position 0, ring not yet full
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

[rtl/per_channel_window_minimum.sv]
// Per-channel sliding window minimum filter, top level.
// Depends on pcwm_pkg, pcwm_hist_mem and pcwm_ptr_mem.
//
// Usage:
//   s_axis carries one reading per transfer: channel number and 16-bit range.
//   m_axis returns exactly one result per input transfer, in order: the
//   channel echoed, the minimum of that channel's last window_length readings
//   (new one included) and a bad-channel flag in tuser. A channel at or above
//   CHANNELS stores nothing and returns min_range = 0 with the flag set.
//   cfg carries window_length; write it only while the block is idle. Values
//   of 0 act as 1, values above AGE_MAX act as AGE_MAX.
// Timing:
//   One item is processed at a time. From an input transfer to result valid
//   the sequencer makes one pointer-memory read, then one history read per
//   older slot (w - 1; w = effective window), pipelined one per cycle
//   through the history RAM read port, then the output load. A bad channel
//   skips the reads and goes straight to the output load. The next input
//   is accepted the cycle after the result is loaded, so no new reading is
//   taken before the last one is through.
// Reset:
//   arst_n clears the pointer valid bits, so every channel restarts with an
//   empty ring; unwritten history slots are masked and count as 0xFFFF.
//   No clearing pass is needed. window_length returns to 4.
// Stall:
//   The output register holds a finished result while m_axis_tready is low;
//   a new input may be accepted meanwhile, and its result waits in the
//   sequencer until the output register frees up.
module per_channel_window_minimum #(
	parameter int unsigned CHANNELS = 64,
	parameter int unsigned AGE_MAX  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,        // [3:0] window_length
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // [7:0] channel, [23:8] range_value
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,    // [7:0] channel_out, [23:8] min_range
	output logic        m_axis_tuser     // [0] bad_channel
);
	import pcwm_pkg::*;

	localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned PW    = (AGE_MAX > 1) ? $clog2(AGE_MAX) : 1;
	localparam int unsigned KW    = $clog2(AGE_MAX + 1);
	localparam int unsigned DEPTH = CHANNELS * AGE_MAX;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// ---------------- state ----------------
	seq_state_t         state_q, state_d;
	logic [WIN_W-1:0]   window_q;
	logic [CH_W-1:0]    ch_q;
	logic [RANGE_W-1:0] val_q;
	logic               bad_q;
	logic [AW-1:0]      base_q;
	logic [KW-1:0]      w_q;
	logic [PW-1:0]      pos_q;
	logic               full_q;
	logic [KW-1:0]      k_q;        // age of the outstanding history read
	logic [RANGE_W-1:0] min_q;
	logic               out_valid_q;
	result_t            out_q;

	// ---------------- combinational ----------------
	logic               in_xfer;
	logic               in_bad;
	logic [CH_W-1:0]    in_ch;
	logic [RANGE_W-1:0] in_val;
	logic [KW-1:0]      w_eff;
	logic [AW-1:0]      in_base;
	logic               ptr_rd_en, ptr_wr_en;
	logic [PW:0]        ptr_rd, ptr_wr;
	logic [PW-1:0]      cur_pos, nxt_pos;
	logic               cur_full, wrap;
	logic               hist_wr_en, hist_rd_en;
	logic [AW-1:0]      hist_wr_addr, hist_rd_addr;
	logic [RANGE_W-1:0] hist_rd;
	logic [KW-1:0]      rd_k;
	logic [PW-1:0]      rd_pos;
	logic [7:0]         slot_tmp;
	logic [PW-1:0]      rd_slot;
	logic               slot_live;
	logic               out_load;

	assign in_ch  = s_axis_tdata[7:0];
	assign in_val = s_axis_tdata[23:8];
	assign in_bad = ({1'b0, in_ch} >= 9'(CHANNELS));
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign in_base = AW'(AW'(in_ch[CW-1:0]) * AW'(AGE_MAX));

	always_comb begin
		if (window_q == '0) begin
			w_eff = KW'(1);
		end else if ({4'b0, window_q} > 8'(AGE_MAX)) begin
			w_eff = KW'(AGE_MAX);
		end else begin
			w_eff = KW'(window_q);
		end
	end

	// pointer entry: {full, pos}
	assign cur_pos  = ptr_rd[PW-1:0];
	assign cur_full = ptr_rd[PW];
	assign wrap     = ({1'b0, 8'(cur_pos)} == 9'(AGE_MAX - 1));
	assign nxt_pos  = wrap ? '0 : PW'(cur_pos + 1'b1);
	assign ptr_wr   = {cur_full | wrap, nxt_pos};

	// slot of age rd_k behind rd_pos, modulo AGE_MAX
	always_comb begin
		slot_tmp = 8'(rd_pos) + 8'(AGE_MAX) - 8'(rd_k);
		if (slot_tmp >= 8'(AGE_MAX)) begin
			slot_tmp = slot_tmp - 8'(AGE_MAX);
		end
		rd_slot = PW'(slot_tmp);
	end
	assign hist_rd_addr = base_q + AW'(rd_slot);
	assign hist_wr_addr = base_q + AW'(cur_pos);

	// a slot counts only if written since reset
	assign slot_live = full_q || (8'(pos_q) >= 8'(k_q));

	assign out_load = !out_valid_q || m_axis_tready;

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		ptr_rd_en  = 1'b0;
		ptr_wr_en  = 1'b0;
		hist_wr_en = 1'b0;
		hist_rd_en = 1'b0;
		rd_k       = k_q + 1'b1;
		rd_pos     = pos_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					ptr_rd_en = !in_bad;
					state_d   = in_bad ? ST_DONE : ST_PTR;
				end
			end
			ST_PTR: begin
				ptr_wr_en  = 1'b1;
				hist_wr_en = 1'b1;
				rd_k       = KW'(1);
				rd_pos     = cur_pos;
				hist_rd_en = (w_q > KW'(1));
				state_d    = (w_q > KW'(1)) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (KW'(k_q + 1'b1) < w_q) begin
					hist_rd_en = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q   <= in_ch;
			val_q  <= in_val;
			bad_q  <= in_bad;
			base_q <= in_base;
			w_q    <= w_eff;
			min_q  <= '0;
		end
		if (state_q == ST_PTR) begin
			pos_q  <= cur_pos;
			full_q <= cur_full;
			min_q  <= val_q;
		end
		if (hist_rd_en) begin
			k_q <= rd_k;
		end
		if (state_q == ST_SCAN && slot_live && hist_rd < min_q) begin
			min_q <= hist_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_load) begin
			out_q.bad       <= bad_q;
			out_q.min_range <= min_q;
			out_q.channel   <= ch_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.min_range, out_q.channel};
	assign m_axis_tuser  = out_q.bad;

	// pointer and history memories; sequencing keeps their accesses apart
	pcwm_ptr_mem #(
		.DEPTH(CHANNELS),
		.CW   (CW),
		.DW   (PW + 1)
	) u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (ptr_wr_en),
		.wr_addr(ch_q[CW-1:0]),
		.wr_data(ptr_wr),
		.rd_en  (ptr_rd_en),
		.rd_addr(in_ch[CW-1:0]),
		.rd_data(ptr_rd)
	);

	pcwm_hist_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_hist (
		.clk    (clk),
		.wr_en  (hist_wr_en),
		.wr_addr(hist_wr_addr),
		.wr_data(val_q),
		.rd_en  (hist_rd_en),
		.rd_addr(hist_rd_addr),
		.rd_data(hist_rd)
	);

endmodule

[rtl/pcwm_check.sv]
// Port-level checks for per_channel_window_minimum, plus the bind that attaches them.
// Sees only the top-level ports; no package needed.
module pcwm_check #(
	parameter int unsigned CHANNELS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// reset clears result valid asynchronously, so the output is empty once reset is sampled low
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	a_bad_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			({1'b0, m_axis_tdata[7:0]} >= 9'(CHANNELS)) && (m_axis_tdata[23:8] == 16'd0))
		else $error("bad-channel result with in-range channel or nonzero minimum");

	a_good_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> ({1'b0, m_axis_tdata[7:0]} < 9'(CHANNELS)))
		else $error("good result for out-of-range channel");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind per_channel_window_minimum pcwm_check #(.CHANNELS(CHANNELS)) u_pcwm_check (.*);

[sim/per_channel_window_minimum_test.sv]
// Self-checking testbench for per_channel_window_minimum: readings go in over s_axis,
// minima come back over m_axis, cfg sets window_length between phases.
// Depends on pcwm_pkg and the per_channel_window_minimum RTL.
module per_channel_window_minimum_test;
	import pcwm_pkg::*;

	localparam int unsigned CHANNELS   = 64;
	localparam int unsigned AGE_MAX    = 8;       // ring index below relies on 8 slots
	localparam int unsigned CH_IDX_W   = $clog2(CHANNELS);
	localparam int unsigned CYCLE_CAP  = 600000;
	localparam int unsigned PHASES     = 8;
	localparam int unsigned PHASE_ITEMS = 175;

	// Traffic shaping per phase
	typedef enum logic [1:0] {
		TRAFFIC_FREE,
		TRAFFIC_SEND_IDLE,
		TRAFFIC_RECV_STALL,
		TRAFFIC_BOTH
	} traffic_mode_t;

	// Shadow copy of the filter state; one expected result per accepted reading.
	class minimum_scoreboard;
		logic [RANGE_W-1:0] history [CHANNELS][AGE_MAX];
		logic [2:0]         ring_pos [CHANNELS];
		logic [WIN_W-1:0]   window_len;
		result_t            expected_minima[$];
		int unsigned        mismatches;
		int unsigned        results_seen;
		int unsigned        bad_seen;

		function new();
			foreach (history[c, s]) history[c][s] = FULL_RANGE;
			foreach (ring_pos[c]) ring_pos[c] = '0;
			window_len   = WIN_RESET;
			mismatches   = 0;
			results_seen = 0;
			bad_seen     = 0;
		endfunction

		function void set_window(logic [WIN_W-1:0] w);
			window_len = w;
		endfunction

		function int unsigned outstanding();
			return expected_minima.size();
		endfunction

		// Store the reading, then search the newest w slots of that channel's ring.
		function void note_reading(logic [CH_W-1:0] ch, logic [RANGE_W-1:0] val);
			result_t             r;
			int unsigned         w;
			int unsigned         k;
			logic [2:0]          slot;
			logic [RANGE_W-1:0]  least;
			logic [CH_IDX_W-1:0] ci;
			r.channel = ch;
			if (ch >= CHANNELS) begin
				// out-of-range channel: nothing stored, pointer untouched
				r.bad       = 1'b1;
				r.min_range = '0;
			end else begin
				ci = ch[CH_IDX_W-1:0];
				history[ci][ring_pos[ci]] = val;
				w = 32'(window_len);
				if (w < 1) w = 1;
				if (w > AGE_MAX) w = AGE_MAX;
				least = val;
				for (k = 1; k < w; k++) begin
					slot = ring_pos[ci] - k[2:0];
					if (history[ci][slot] < least) least = history[ci][slot];
				end
				ring_pos[ci] = ring_pos[ci] + 3'd1;
				r.bad       = 1'b0;
				r.min_range = least;
			end
			expected_minima.push_back(r);
		endfunction

		function void check_result(logic [23:0] data, logic usr);
			result_t want;
			results_seen++;
			if (usr) bad_seen++;
			if (expected_minima.size() == 0) begin
				$error("result with nothing outstanding: channel_out=%0d min_range=%0d",
					data[7:0], data[23:8]);
				mismatches++;
				return;
			end
			want = expected_minima.pop_front();
			if (data[7:0] !== want.channel) begin
				$error("channel_out: expected %0d, got %0d", want.channel, data[7:0]);
				mismatches++;
			end
			if (data[23:8] !== want.min_range) begin
				$error("min_range: expected %0d, got %0d", want.min_range, data[23:8]);
				mismatches++;
			end
			if (usr !== want.bad) begin
				$error("bad_channel: expected %0d, got %0d", want.bad, usr);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data       = WIN_RESET;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata   = '0;   // [7:0] channel, [23:8] range_value
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	logic [23:0] m_axis_tdata;          // [7:0] channel_out, [23:8] min_range
	logic        m_axis_tuser;          // [0] bad_channel

	traffic_mode_t      traffic = TRAFFIC_FREE;
	minimum_scoreboard  board;
	int unsigned        cycles = 0;
	logic [CH_W-1:0]    hot_ch [4];

	per_channel_window_minimum #(
		.CHANNELS (CHANNELS),
		.AGE_MAX  (AGE_MAX)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("per_channel_window_minimum_test: FAIL");
			$finish;
		end
	end

	// Input monitor: every accepted transfer feeds the predictor.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_reading(s_axis_tdata[7:0], s_axis_tdata[23:8]);
	end

	// Result side: check accepted transfers, then pick next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (traffic == TRAFFIC_RECV_STALL)
			m_axis_tready <= ($urandom_range(99) >= 85);
		else if (traffic == TRAFFIC_BOTH)
			m_axis_tready <= ($urandom_range(99) >= 21);
		else
			m_axis_tready <= 1'b1;
	end

	// One reading transfer; tvalid stays high on return so back-to-back items
	// follow with no idle gap unless the traffic mode inserts gaps.
	task automatic push_reading(input logic [CH_W-1:0] ch, input logic [RANGE_W-1:0] val);
		int unsigned idle_pct;
		idle_pct = (traffic == TRAFFIC_SEND_IDLE) ? 85 : (traffic == TRAFFIC_BOTH) ? 21 : 0;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, ch};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid and wait until every outstanding minimum has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_window(w);
	endtask

	// Random reading: mostly a few busy channels so rings wrap often, some
	// spread over all channels, some out of range.
	task automatic push_random();
		int unsigned     pick;
		logic [CH_W-1:0] ch;
		logic [RANGE_W-1:0] val;
		pick = $urandom_range(99);
		if (pick < 10)
			ch = CH_W'($urandom_range(255, CHANNELS));
		else if (pick < 70)
			ch = hot_ch[2'($urandom_range(3))];
		else
			ch = CH_W'($urandom_range(CHANNELS - 1));
		pick = $urandom_range(99);
		if (pick < 8)
			val = '0;
		else if (pick < 16)
			val = FULL_RANGE;
		else if (pick < 50)
			val = RANGE_W'(16'd1000 + $urandom_range(255));   // close values: comparisons matter
		else
			val = RANGE_W'($urandom_range(16'hFFFF));
		push_reading(ch, val);
	endtask

	initial begin
		logic [WIN_W-1:0] windows [PHASES];
		int unsigned      p;
		int unsigned      n;
		board = new();
		windows = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd7, 4'd3};
		hot_ch[0] = 8'd0;
		hot_ch[1] = CH_W'(CHANNELS - 1);
		hot_ch[2] = CH_W'($urandom_range(CHANNELS - 1));
		hot_ch[3] = CH_W'($urandom_range(CHANNELS - 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, at the reset window of 4: unwritten slots read as full range,
		// the window slides over channel 0, channel extremes and bad channels.
		push_reading(8'd0, 16'hFFFF);
		push_reading(8'd0, 16'd100);
		push_reading(8'd0, 16'd50);
		push_reading(8'd0, 16'd200);
		push_reading(8'd0, 16'd300);
		push_reading(8'd0, 16'd400);
		push_reading(8'd0, 16'd500);
		push_reading(8'd0, 16'd600);
		push_reading(8'd0, 16'd700);
		push_reading(8'd0, 16'd0);
		push_reading(CH_W'(CHANNELS - 1), 16'd0);
		push_reading(CH_W'(CHANNELS - 1), 16'hFFFF);
		push_reading(CH_W'(CHANNELS), 16'h1234);       // first out-of-range channel
		push_reading(8'd255, 16'hFFFF);
		push_reading(8'd170, 16'h5555);
		push_reading(8'd1, 16'd0);
		push_reading(8'd2, 16'hFFFF);
		push_reading(8'd1, 16'hAAAA);
		push_reading(8'd0, 16'd9);
		push_reading(8'd0, 16'd8);
		drain_results();

		// Each phase: new window (extremes and out-of-range values among them)
		// on top of the history left by the previous one, then random traffic.
		for (p = 0; p < PHASES; p++) begin
			traffic = traffic_mode_t'(p % 4);
			write_window(windows[p]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				push_random();
				// sender holds off mid-phase until the pipe is empty
				if (n == PHASE_ITEMS / 2 && (p == 1 || p == 6))
					drain_results();
			end
			drain_results();
		end

		// window back to its reset value, short burst with no idling
		traffic = TRAFFIC_FREE;
		write_window(WIN_RESET);
		for (n = 0; n < 25; n++) push_random();
		drain_results();
		repeat (20) @(posedge clk);

		$display("checked %0d results (%0d out-of-range channels) over %0d window settings",
			board.results_seen, board.bad_seen, PHASES + 1);
		$display("traffic covered free flow, sender gaps, receiver stalls and both together");
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("per_channel_window_minimum_test: PASS");
		end else begin
			$display("per_channel_window_minimum_test: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/pcwm_pkg.sv
rtl/pcwm_hist_mem.sv
rtl/pcwm_ptr_mem.sv
rtl/per_channel_window_minimum.sv
rtl/pcwm_check.sv
sim/per_channel_window_minimum_test.sv
